// ===== hw/rtl/fbds_pkg.sv =====
// Shared types and constants for the fractional baud divisor search core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fbds_pkg;

	localparam int CLK_W     = 28;              // core clock register
	localparam int BAUD_W    = 22;              // target baud
	localparam int PRE_SHIFT = 6;               // divide by 4, then by 16
	localparam int BASE_W    = CLK_W - PRE_SHIFT;
	localparam int FRAC_W    = 4;
	localparam int PROD_W    = BASE_W + FRAC_W; // mul * base
	localparam int DVD_W     = PROD_W;          // divider dividend width
	localparam int DVS_W     = BAUD_W;          // divider divisor width
	localparam int DCNT_W    = $clog2(DVD_W);
	localparam int DIV_W     = 16;              // divisor latch width
	localparam int ERR_W     = 17;

	localparam logic [ERR_W-1:0]  ERR_LIMIT = ERR_W'(100000);
	localparam logic [FRAC_W-1:0] FRAC_MAX  = FRAC_W'(15);
	localparam logic [DIV_W-1:0]  DIV_MIN   = DIV_W'(3);

	// divider operand selects
	localparam logic [1:0] SEL_TEMP = 2'd0;   // mul*base / (mul+add)
	localparam logic [1:0] SEL_DV   = 2'd1;   // temp / baud
	localparam logic [1:0] SEL_ACH  = 2'd2;   // temp / dv

	typedef struct packed {
		logic       load;
		logic       prod;
		logic       div_start;
		logic [1:0] div_sel;
		logic       take_temp;
		logic       take_dv;
		logic       take_ach;
		logic       step;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic baud_zero;
		logic div_done;
		logic dv_ok;
		logic exact;
		logic row_end;
		logic last_mul;
		logic seen;
	} status_t;

endpackage

// ===== hw/rtl/fbds_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on fbds_pkg for operand widths.
`timescale 1ns / 1ps

module fbds_div
	import fbds_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] dvs,
	output logic             done,
	output logic [DVD_W-1:0] quo,
	output logic [DVS_W-1:0] rem
);

	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    shifted;
	logic [DVS_W:0]    diff;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (busy_q) begin
			// no borrow: partial remainder covers the divisor
			if (!diff[DVS_W]) begin
				rem_q <= diff[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/fbds_dp.sv =====
// Datapath: clock register, candidate counters, shared divider, best-so-far and
// result registers. Depends on fbds_pkg and fbds_div.
`timescale 1ns / 1ps

module fbds_dp
	import fbds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CLK_W-1:0]  cfg_data,
	input  logic [BAUD_W-1:0] baud_in,
	input  cmd_t              cmd,
	output status_t           sts,
	output logic [DIV_W-1:0]  res_div,
	output logic [FRAC_W-1:0] res_mul,
	output logic [FRAC_W-1:0] res_add,
	output logic [ERR_W-1:0]  res_err,
	output logic              res_found
);

	logic [CLK_W-1:0]  clk_hz_q;
	logic [BAUD_W-1:0] baud_q;
	logic [FRAC_W-1:0] mul_q;
	logic [FRAC_W-1:0] add_q;
	logic [PROD_W-1:0] prod_q;
	logic [BASE_W-1:0] temp_q;
	logic [DIV_W-1:0]  dv_q;
	logic              dv_ok_q;
	logic              exact_q;
	logic              seen_q;
	logic [FRAC_W-1:0] best_mul_q;
	logic [FRAC_W-1:0] best_add_q;
	logic [DIV_W-1:0]  best_div_q;
	logic [ERR_W-1:0]  best_err_q;
	logic [DIV_W-1:0]  res_div_q;
	logic [FRAC_W-1:0] res_mul_q;
	logic [FRAC_W-1:0] res_add_q;
	logic [ERR_W-1:0]  res_err_q;
	logic              res_found_q;

	logic [BASE_W-1:0] base;
	logic [FRAC_W:0]   mul_add;
	logic [DVD_W-1:0]  op_dvd;
	logic [DVS_W-1:0]  op_dvs;
	logic              div_done;
	logic [DVD_W-1:0]  div_quo;
	logic [DVS_W-1:0]  div_rem;
	logic              round_up;
	logic [DVD_W:0]    dv_full;
	logic [BASE_W-1:0] ach;
	logic [BASE_W-1:0] err;
	logic              better;

	assign base    = clk_hz_q[CLK_W-1:PRE_SHIFT];
	assign mul_add = {1'b0, mul_q} + {1'b0, add_q};

	always_comb begin
		case (cmd.div_sel)
			SEL_TEMP: begin
				op_dvd = prod_q;
				op_dvs = DVS_W'(mul_add);
			end
			SEL_DV: begin
				op_dvd = DVD_W'(temp_q);
				op_dvs = baud_q;
			end
			SEL_ACH: begin
				op_dvd = DVD_W'(temp_q);
				op_dvs = DVS_W'(dv_q);
			end
			default: begin
				op_dvd = prod_q;
				op_dvs = DVS_W'(mul_add);
			end
		endcase
	end

	fbds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (op_dvd),
		.dvs      (op_dvs),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// round to nearest: bump when remainder exceeds half the baud
	assign round_up = div_rem > {1'b0, baud_q[BAUD_W-1:1]};
	assign dv_full  = {1'b0, div_quo} + (DVD_W+1)'(round_up);

	assign ach    = div_quo[BASE_W-1:0];
	assign err    = (ach >= baud_q) ? (ach - baud_q) : (baud_q - ach);
	assign better = err < BASE_W'(best_err_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q   <= CLK_W'(100000000);
			mul_q      <= FRAC_W'(1);
			best_err_q <= ERR_LIMIT;
		end else begin
			if (cfg_we)
				clk_hz_q <= cfg_data;
			if (cmd.load) begin
				mul_q      <= FRAC_W'(1);
				best_err_q <= ERR_LIMIT;
			end else begin
				if (cmd.step && add_q == FRAC_MAX)
					mul_q <= mul_q + 1'b1;
				if (cmd.take_ach && better)
					best_err_q <= err[ERR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			baud_q     <= baud_in;
			add_q      <= '0;
			seen_q     <= 1'b0;
			best_mul_q <= FRAC_W'(1);
			best_add_q <= '0;
			best_div_q <= '0;
		end
		if (cmd.step)
			add_q <= (add_q == FRAC_MAX) ? '0 : add_q + 1'b1;
		if (cmd.prod)
			prod_q <= PROD_W'(mul_q) * PROD_W'(base);
		if (cmd.take_temp)
			temp_q <= div_quo[BASE_W-1:0];
		if (cmd.take_dv) begin
			dv_q    <= dv_full[DIV_W-1:0];
			dv_ok_q <= (dv_full[DVD_W:DIV_W] == '0) && (dv_full[DIV_W-1:0] >= DIV_MIN);
		end
		if (cmd.take_ach) begin
			seen_q  <= 1'b1;
			exact_q <= better && (err == '0);
			if (better) begin
				best_mul_q <= mul_q;
				best_add_q <= add_q;
				best_div_q <= dv_q;
			end
		end
		if (cmd.out_load) begin
			res_div_q   <= best_div_q;
			res_mul_q   <= best_mul_q;
			res_add_q   <= best_add_q;
			res_err_q   <= best_err_q;
			res_found_q <= best_err_q < ERR_LIMIT;
		end
	end

	assign sts.baud_zero = (baud_q == '0);
	assign sts.div_done  = div_done;
	assign sts.dv_ok     = dv_ok_q;
	assign sts.exact     = exact_q;
	assign sts.row_end   = (add_q == FRAC_MAX);
	assign sts.last_mul  = (mul_q == FRAC_MAX);
	assign sts.seen      = seen_q;

	assign res_div   = res_div_q;
	assign res_mul   = res_mul_q;
	assign res_add   = res_add_q;
	assign res_err   = res_err_q;
	assign res_found = res_found_q;

	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		best_err_q <= ERR_LIMIT)
		else $error("best error above limit");

	a_mul_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		mul_q != '0)
		else $error("multiplier counter wrapped to zero");

	a_best_needs_valid_dv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_ach |-> dv_ok_q)
		else $error("achieved rate taken for an out-of-range divisor");

endmodule

// ===== hw/rtl/fbds_ctrl.sv =====
// Controller: sequences the candidate search over the datapath and runs the
// input/output handshakes. Depends on fbds_pkg.
`timescale 1ns / 1ps

module fbds_ctrl
	import fbds_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t sts,
	output cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PROD = 4'd1;
	localparam logic [3:0] ST_D1   = 4'd2;
	localparam logic [3:0] ST_W1   = 4'd3;
	localparam logic [3:0] ST_D2   = 4'd4;
	localparam logic [3:0] ST_W2   = 4'd5;
	localparam logic [3:0] ST_CHK  = 4'd6;
	localparam logic [3:0] ST_D3   = 4'd7;
	localparam logic [3:0] ST_W3   = 4'd8;
	localparam logic [3:0] ST_EVAL = 4'd9;
	localparam logic [3:0] ST_NEXT = 4'd10;
	localparam logic [3:0] ST_FIN  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       out_valid_q;
	logic       in_xfer;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					cmd.load = 1'b1;
					state_nx = ST_PROD;
				end
			end
			ST_PROD: begin
				if (sts.baud_zero) begin
					state_nx = ST_FIN;
				end else begin
					cmd.prod = 1'b1;
					state_nx = ST_D1;
				end
			end
			ST_D1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = SEL_TEMP;
				state_nx      = ST_W1;
			end
			ST_W1: begin
				if (sts.div_done) begin
					cmd.take_temp = 1'b1;
					state_nx      = ST_D2;
				end
			end
			ST_D2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = SEL_DV;
				state_nx      = ST_W2;
			end
			ST_W2: begin
				if (sts.div_done) begin
					cmd.take_dv = 1'b1;
					state_nx    = ST_CHK;
				end
			end
			ST_CHK: begin
				state_nx = sts.dv_ok ? ST_D3 : ST_NEXT;
			end
			ST_D3: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = SEL_ACH;
				state_nx      = ST_W3;
			end
			ST_W3: begin
				if (sts.div_done) begin
					cmd.take_ach = 1'b1;
					state_nx     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_nx = sts.exact ? ST_FIN : ST_NEXT;
			end
			ST_NEXT: begin
				// the last row, or a row with no valid divisor seen so far, ends the search
				if (sts.row_end && (sts.last_mul || !sts.seen)) begin
					state_nx = ST_FIN;
				end else begin
					cmd.step = 1'b1;
					state_nx = ST_PROD;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("pending result overwritten");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input not stalled during search");

	a_single_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !cmd.div_start)
		else $error("divider restarted back to back");

endmodule

// ===== hw/rtl/fractional_baud_divisor_search_core.sv =====
// Fractional baud divisor search core.
// Input channel (in_valid/in_stall, target_baud): one transfer starts a search.
// Output channel (out_valid/out_stall): one result transfer per search, with
//   divisor, frac_mul, frac_add, baud_error and found.
// Config channel (cfg_valid/cfg_ready, core_clock_hz): sets the core clock in
//   hertz; always ready, write only while no search is running. Reset value is
//   100 MHz.
// Each candidate (multiplier 1..15, add 0..15) runs up to three divisions on
//   one shared restoring divider that yields one quotient bit per cycle; a
//   candidate whose divisor is out of range skips the third. A full search
//   covers 240 candidates; a search ends early after the first row if it
//   found no valid divisor there, or on an exact match. A zero target baud
//   runs no division and goes straight to the result. One search runs at a
//   time.
// in_stall is high while a search runs; the next target is taken as soon as
//   the previous result sits in the output register. A stalled result holds
//   there, and a finished search waits until the output register is free.
// Asynchronous reset clears the controller, output valid and divider control,
//   and resets the clock register, multiplier counter and best error.
// Depends on fbds_pkg, fbds_ctrl, fbds_dp (with fbds_div).
`timescale 1ns / 1ps

module fractional_baud_divisor_search_core
	import fbds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CLK_W-1:0]  core_clock_hz,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BAUD_W-1:0] target_baud,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DIV_W-1:0]  divisor,
	output logic [FRAC_W-1:0] frac_mul,
	output logic [FRAC_W-1:0] frac_add,
	output logic [ERR_W-1:0]  baud_error,
	output logic              found
);

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	fbds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fbds_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (core_clock_hz),
		.baud_in   (target_baud),
		.cmd       (cmd),
		.sts       (sts),
		.res_div   (divisor),
		.res_mul   (frac_mul),
		.res_add   (frac_add),
		.res_err   (baud_error),
		.res_found (found)
	);

endmodule
